@@ hw/rtl/sst_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and codes of the sparse set table.
package sst_pkg;

	localparam int ID_W         = 8;
	localparam int ID_SPACE     = 256;
	localparam int DATA_W       = 32;
	localparam int COUNT_OUT_W  = 9;
	localparam int CAPACITY_DEF = 256;

	typedef enum logic [1:0] {
		CMD_ADD = 2'd0,
		CMD_SET = 2'd1,
		CMD_GET = 2'd2,
		CMD_REM = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_EXEC,
		ST_RESP
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;  // capture a new item
		logic look;  // issue the table reads
		logic exec;  // decide and write back
	} ctrl_t;

endpackage

@@ hw/rtl/sst_ram.sv @@
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
module sst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ hw/rtl/sst_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer: lookup, execute and respond phases of each item.
module sst_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output logic          done,
	output sst_pkg::ctrl_t ctrl
);

	import sst_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b0;
		done      = 1'b0;
		ctrl.load = 1'b0;
		ctrl.look = 1'b0;
		ctrl.exec = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = ST_LOOK;
				end
			end
			ST_LOOK: begin
				busy      = 1'b1;
				ctrl.look = 1'b1;
				state_d   = ST_EXEC;
			end
			ST_EXEC: begin
				busy      = 1'b1;
				ctrl.exec = 1'b1;
				state_d   = ST_RESP;
			end
			ST_RESP: begin
				// result shown; next item may be taken in the same cycle
				done = 1'b1;
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = ST_LOOK;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/sst_dpath.sv @@
`timescale 1ns / 1ps
// Datapath: present bits, three tables, live count and result registers.
module sst_dpath #(
	parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sst_pkg::ctrl_t                  ctrl,
	input  logic [1:0]                      cmd,
	input  logic [sst_pkg::ID_W-1:0]        key_id,
	input  logic [sst_pkg::DATA_W-1:0]      payload,
	output logic                            ok,
	output logic [sst_pkg::DATA_W-1:0]      read_data,
	output logic [sst_pkg::COUNT_OUT_W-1:0] entry_count
);

	import sst_pkg::*;

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	cmd_t              cmd_q;
	logic [ID_W-1:0]   id_q;
	logic [DATA_W-1:0] data_q;
	logic              present_q [ID_SPACE];
	logic [CW-1:0]     count_q;
	logic              ok_q;
	logic              rd_en_q;

	logic [SW-1:0]     last_slot;
	logic [SW-1:0]     tail_slot;
	logic [SW-1:0]     freed;
	logic [ID_W-1:0]   moved;
	logic [DATA_W-1:0] pay_rd;
	logic              pres;
	logic              add_ok;
	logic              do_move;
	logic              op_ok;

	logic              sid_we, ios_we, pay_we, pay_re;
	logic [ID_W-1:0]   sid_waddr;
	logic [SW-1:0]     sid_wdata;
	logic [SW-1:0]     ios_waddr, pay_waddr, pay_raddr;
	logic [ID_W-1:0]   ios_wdata;
	logic [DATA_W-1:0] pay_wdata;
	logic [CW+COUNT_OUT_W-1:0] count_wide;

	assign tail_slot = count_q[SW-1:0];
	assign last_slot = count_q[SW-1:0] - SW'(1);
	assign pres      = present_q[id_q];
	assign add_ok    = (cmd_q == CMD_ADD) && !pres && (count_q < CW'(CAPACITY));
	assign do_move   = (cmd_q == CMD_REM) && pres && (freed != last_slot);

	always_comb begin
		case (cmd_q)
			CMD_ADD: op_ok = add_ok;
			CMD_SET: op_ok = pres;
			CMD_GET: op_ok = pres;
			CMD_REM: op_ok = pres;
			default: op_ok = 1'b0;
		endcase
	end

	// write-back in the execute phase
	always_comb begin
		sid_we    = 1'b0;
		sid_waddr = id_q;
		sid_wdata = tail_slot;
		ios_we    = 1'b0;
		ios_waddr = tail_slot;
		ios_wdata = id_q;
		pay_we    = 1'b0;
		pay_waddr = tail_slot;
		pay_wdata = data_q;
		if (ctrl.exec) begin
			if (add_ok) begin
				sid_we = 1'b1;
				ios_we = 1'b1;
				pay_we = 1'b1;
			end else if ((cmd_q == CMD_SET) && pres) begin
				pay_we    = 1'b1;
				pay_waddr = freed;
			end else if (do_move) begin
				// last entry fills the freed slot
				sid_we    = 1'b1;
				sid_waddr = moved;
				sid_wdata = freed;
				ios_we    = 1'b1;
				ios_waddr = freed;
				ios_wdata = moved;
				pay_we    = 1'b1;
				pay_waddr = freed;
				pay_wdata = pay_rd;
			end
		end
	end

	// payload read: tail entry in lookup, hit slot in execute (get)
	assign pay_re    = ctrl.look || ctrl.exec;
	assign pay_raddr = ctrl.look ? last_slot : freed;

	sst_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_slot_of_id (
		.clk   (clk),
		.we    (sid_we),
		.waddr (sid_waddr),
		.wdata (sid_wdata),
		.re    (ctrl.look),
		.raddr (id_q),
		.rdata (freed)
	);

	sst_ram #(.WIDTH(ID_W), .DEPTH(CAPACITY)) u_id_of_slot (
		.clk   (clk),
		.we    (ios_we),
		.waddr (ios_waddr),
		.wdata (ios_wdata),
		.re    (ctrl.look),
		.raddr (last_slot),
		.rdata (moved)
	);

	sst_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_slot_payload (
		.clk   (clk),
		.we    (pay_we),
		.waddr (pay_waddr),
		.wdata (pay_wdata),
		.re    (pay_re),
		.raddr (pay_raddr),
		.rdata (pay_rd)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_q  <= cmd_t'(cmd);
			id_q   <= key_id;
			data_q <= payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ID_SPACE; i++) begin
				present_q[i] <= 1'b0;
			end
			count_q <= '0;
			ok_q    <= 1'b0;
			rd_en_q <= 1'b0;
		end else if (ctrl.exec) begin
			ok_q    <= op_ok;
			rd_en_q <= (cmd_q == CMD_GET) && pres;
			if (add_ok) begin
				present_q[id_q] <= 1'b1;
				count_q         <= count_q + CW'(1);
			end else if ((cmd_q == CMD_REM) && pres) begin
				present_q[id_q] <= 1'b0;
				count_q         <= count_q - CW'(1);
			end
		end
	end

	assign count_wide  = {{COUNT_OUT_W{1'b0}}, count_q};
	assign ok          = ok_q;
	assign read_data   = rd_en_q ? pay_rd : '0;
	assign entry_count = count_wide[COUNT_OUT_W-1:0];

endmodule

@@ hw/rtl/sparse_set_table_unit.sv @@
`timescale 1ns / 1ps
// The result is strobed on done in the respond state, after the lookup and execute states.
// No new item is taken in lookup or execute; a new start is taken while done shows the last result.
// Lookup is a state of its own for the dependent reads of the slot and id tables before write-back.
// Reset (arst_n low, async): present bits and live count cleared, sequencer idle.
// Table contents are not cleared; only written entries are ever used. done cannot be stalled.
module sparse_set_table_unit #(
	parameter int CAPACITY = sst_pkg::CAPACITY_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	output logic                            busy,
	input  logic [1:0]                      cmd,
	input  logic [sst_pkg::ID_W-1:0]        key_id,
	input  logic [sst_pkg::DATA_W-1:0]      payload,
	output logic                            done,
	output logic                            ok,
	output logic [sst_pkg::DATA_W-1:0]      read_data,
	output logic [sst_pkg::COUNT_OUT_W-1:0] entry_count
);

	import sst_pkg::*;

	ctrl_t ctrl;

	// Sequencer: idle -> lookup -> execute -> respond. busy covers lookup and
	// execute only, so the next item is taken in the respond cycle.
	sst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.ctrl   (ctrl)
	);

	// Datapath: lookup reads slot_of_id[id] and the tail entry of the packed
	// tables; execute appends, overwrites, or swaps the tail into the freed
	// slot on remove; a get reads the hit slot in execute and shows it on done.
	sst_dpath #(.CAPACITY(CAPACITY)) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.cmd         (cmd),
		.key_id      (key_id),
		.payload     (payload),
		.ok          (ok),
		.read_data   (read_data),
		.entry_count (entry_count)
	);

	// every accepted item is answered on done once its lookup and execute states have passed
	a_resp_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("result strobe missing three cycles after accept");

	// no result while an item is still in lookup or execute
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// the count moves only when a result is shown
	a_count_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(entry_count) |-> done)
		else $error("entry count changed outside a result");

	// read data is only returned by a successful operation
	a_rdata_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (read_data != '0)) |-> ok)
		else $error("read data on a failed operation");

endmodule

@@ tb/sparse_set_table_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the sparse set table: directed rows, then random fill, churn and drain.
module sparse_set_table_unit_tb;
	import sst_pkg::*;

	localparam int CAP   = CAPACITY_DEF;
	localparam int LIMIT = 200000;  // watchdog limit, in cycles
	localparam int TAIL  = 12;      // settle time after the last result
	localparam int N_DIR = 25;

	// one result item: the three result fields in port order
	typedef struct packed {
		logic                   ok;
		logic [DATA_W-1:0]      rd;
		logic [COUNT_OUT_W-1:0] cnt;
	} reply_t;

	// directed stimulus row; typed rows carry a hand-written result
	typedef struct packed {
		cmd_t              op;
		logic [ID_W-1:0]   id;
		logic [DATA_W-1:0] pl;
		logic              typed;
		reply_t            want;
	} row_t;

	logic                   clk         = 1'b0;
	logic                   arst_n      = 1'b0;
	logic                   start       = 1'b0;
	logic [1:0]             cmd         = CMD_ADD;
	logic [ID_W-1:0]        key_id      = '0;
	logic [DATA_W-1:0]      payload     = '0;
	logic                   busy;
	logic                   done;
	logic                   ok;
	logic [DATA_W-1:0]      read_data;
	logic [COUNT_OUT_W-1:0] entry_count;

	// shadow copy of the store, updated when an item is accepted
	bit                held     [ID_SPACE];
	logic [ID_W-1:0]   slot_for [ID_SPACE];
	logic [ID_W-1:0]   key_at   [CAP];
	logic [DATA_W-1:0] data_at  [CAP];
	int unsigned       live = 0;

	reply_t      replies_due [$];
	reply_t      seen;
	reply_t      due;
	int unsigned mismatches = 0;
	int unsigned cycles     = 0;
	int unsigned burst_left = 1;

	// Directed rows. Covers: ops on an empty store, duplicate add, extreme ids and payloads,
	// remove that moves the last slot down, remove of the last slot (nothing moves),
	// repeated remove, set/get of an absent id. The tail rows go through the shadow store.
	row_t dir_rows [N_DIR] = '{
		'{CMD_GET, 8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 9'd0}},
		'{CMD_SET, 8'd255, 32'hffff_ffff, 1'b1, '{1'b0, 32'h0000_0000, 9'd0}},
		'{CMD_REM, 8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 9'd0}},
		'{CMD_ADD, 8'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 9'd1}},
		'{CMD_ADD, 8'd0,   32'h1234_5678, 1'b1, '{1'b0, 32'h0000_0000, 9'd1}},
		'{CMD_ADD, 8'd255, 32'hffff_ffff, 1'b1, '{1'b1, 32'h0000_0000, 9'd2}},
		'{CMD_GET, 8'd255, 32'h0000_0000, 1'b1, '{1'b1, 32'hffff_ffff, 9'd2}},
		'{CMD_GET, 8'd0,   32'hffff_ffff, 1'b1, '{1'b1, 32'h0000_0000, 9'd2}},
		'{CMD_ADD, 8'd128, 32'h5a5a_5a5a, 1'b1, '{1'b1, 32'h0000_0000, 9'd3}},
		'{CMD_SET, 8'd0,   32'ha5a5_a5a5, 1'b1, '{1'b1, 32'h0000_0000, 9'd3}},
		'{CMD_GET, 8'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'ha5a5_a5a5, 9'd3}},
		'{CMD_REM, 8'd0,   32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 9'd2}},
		'{CMD_GET, 8'd128, 32'h0000_0000, 1'b1, '{1'b1, 32'h5a5a_5a5a, 9'd2}},
		'{CMD_GET, 8'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 9'd2}},
		'{CMD_REM, 8'd128, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 9'd1}},
		'{CMD_GET, 8'd255, 32'h0000_0000, 1'b1, '{1'b1, 32'hffff_ffff, 9'd1}},
		'{CMD_REM, 8'd255, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 9'd0}},
		'{CMD_REM, 8'd255, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 9'd0}},
		'{CMD_SET, 8'd7,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 9'd0}},
		'{CMD_ADD, 8'd3,   32'h0000_0001, 1'b0, '0},
		'{CMD_ADD, 8'd4,   32'h8000_0000, 1'b0, '0},
		'{CMD_REM, 8'd3,   32'h0000_0000, 1'b0, '0},
		'{CMD_SET, 8'd4,   32'h7fff_ffff, 1'b0, '0},
		'{CMD_GET, 8'd4,   32'h0000_0000, 1'b0, '0},
		'{CMD_REM, 8'd4,   32'h0000_0000, 1'b0, '0}
	};

	sparse_set_table_unit DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.key_id     (key_id),
		.payload    (payload),
		.done       (done),
		.ok         (ok),
		.read_data  (read_data),
		.entry_count(entry_count)
	);

	always #4 clk = ~clk;

	// Shadow store step: applies one accepted item and returns its result.
	function automatic reply_t sparse_update(cmd_t op, logic [ID_W-1:0] id,
		logic [DATA_W-1:0] pl);
		reply_t          r;
		int unsigned     last;
		int unsigned     freed;
		logic [ID_W-1:0] moved;
		r = '0;
		case (op)
		CMD_ADD: begin
			if (!held[id] && live < CAP) begin
				held[id]      = 1'b1;
				slot_for[id]  = live[ID_W-1:0];
				key_at[live]  = id;
				data_at[live] = pl;
				live++;
				r.ok = 1'b1;
			end
		end
		CMD_SET: begin
			if (held[id]) begin
				data_at[slot_for[id]] = pl;
				r.ok = 1'b1;
			end
		end
		CMD_GET: begin
			if (held[id]) begin
				r.rd = data_at[slot_for[id]];
				r.ok = 1'b1;
			end
		end
		CMD_REM: begin
			if (held[id]) begin
				last  = live - 1;
				freed = 32'(slot_for[id]);
				// swap-remove: last packed entry drops into the hole
				if (freed != last) begin
					moved           = key_at[last];
					slot_for[moved] = freed[ID_W-1:0];
					key_at[freed]   = moved;
					data_at[freed]  = data_at[last];
				end
				held[id] = 1'b0;
				live     = last;
				r.ok     = 1'b1;
			end
		end
		default: begin
		end
		endcase
		r.cnt = live[COUNT_OUT_W-1:0];
		return r;
	endfunction

	// Present the item at a falling edge and hold it until a rising edge sees busy low.
	task automatic issue(cmd_t op, logic [ID_W-1:0] id, logic [DATA_W-1:0] pl,
		logic typed, reply_t want);
		reply_t model;
		@(negedge clk);
		start   <= 1'b1;
		cmd     <= op;
		key_id  <= id;
		payload <= pl;
		do @(posedge clk); while (busy);
		model = sparse_update(op, id, pl);
		replies_due.push_back(typed ? want : model);
	endtask

	// Random item with burst/gap shaping on the sender side.
	task automatic send(cmd_t op, logic [ID_W-1:0] id, logic [DATA_W-1:0] pl);
		int unsigned gap;
		issue(op, id, pl, 1'b0, '0);
		burst_left--;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 8);
			repeat (gap) @(negedge clk) start <= 1'b0;
		end
	endtask

	// Hold off the sender until every pending result has come back.
	task automatic settle();
		@(negedge clk) start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
	endtask

	// id not in the store; only called while there is room
	function automatic logic [ID_W-1:0] fresh_id();
		logic [ID_W-1:0] id;
		do id = ID_W'($urandom_range(0, ID_SPACE - 1)); while (held[id]);
		return id;
	endfunction

	// a present id pct percent of the time, otherwise any id
	function automatic logic [ID_W-1:0] pick_id(int unsigned pct);
		if (live != 0 && $urandom_range(0, 99) < pct)
			return key_at[$urandom_range(0, live - 1)];
		return ID_W'($urandom_range(0, ID_SPACE - 1));
	endfunction

	function automatic cmd_t any_cmd();
		return cmd_t'($urandom_range(0, 3));
	endfunction

	// result check: done is a one-cycle strobe and cannot be held off
	always @(posedge clk) begin
		if (arst_n && done) begin
			seen = {ok, read_data, entry_count};
			if (replies_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: ok=%0b read_data=%h entry_count=%0d",
						seen.ok, seen.rd, seen.cnt);
			end else begin
				due = replies_due.pop_front();
				if (seen.ok !== due.ok || seen.rd !== due.rd || seen.cnt !== due.cnt) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp ok=%0b rd=%h cnt=%0d, got ok=%0b rd=%h cnt=%0d",
							due.ok, due.rd, due.cnt, seen.ok, seen.rd, seen.cnt);
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// directed rows, back to back
		foreach (dir_rows[i])
			issue(dir_rows[i].op, dir_rows[i].id, dir_rows[i].pl, dir_rows[i].typed,
				dir_rows[i].want);
		settle();

		// fill: mostly adds of new ids until the store is full
		while (live < CAP) begin
			if ($urandom_range(0, 3) != 0)
				send(CMD_ADD, fresh_id(), $urandom);
			else
				send(any_cmd(), pick_id(60), $urandom);
		end
		// full store: adds fail until a remove frees a slot; reads and writes still work
		repeat (30) begin
			if ($urandom_range(0, 1) != 0)
				send(CMD_ADD, ID_W'($urandom_range(0, ID_SPACE - 1)), $urandom);
			else
				send(any_cmd(), pick_id(80), $urandom);
		end
		settle();

		// churn: random ops, mostly on present ids
		repeat (300) send(any_cmd(), pick_id(70), $urandom);
		settle();

		// drain: remove until empty, with noise in between
		while (live > 0) begin
			if ($urandom_range(0, 4) != 0)
				send(CMD_REM, pick_id(100), $urandom);
			else
				send(any_cmd(), pick_id(50), $urandom);
		end
		settle();

		// second churn from empty; adds dominate so the store grows again
		repeat (200) begin
			if ($urandom_range(0, 2) == 0 && live < CAP)
				send(CMD_ADD, fresh_id(), $urandom);
			else
				send(any_cmd(), pick_id(70), $urandom);
		end
		settle();

		repeat (TAIL) @(posedge clk);
		if (mismatches == 0 && replies_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
